// ===== design/rtt_pkg.sv =====
package rtt_pkg;

  localparam int unsigned SlotW      = 8;          // slot index width for up to 256 slots
  localparam logic [31:0] TimeWindow = 32'd86400000;

  // register indexes of the cfg channel
  localparam logic [2:0] RegRtt  = 3'd0;
  localparam logic [2:0] RegVar  = 3'd1;
  localparam logic [2:0] RegMult = 3'd2;
  localparam logic [2:0] RegTmin = 3'd3;
  localparam logic [2:0] RegTmax = 3'd4;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_INFLIGHT = 2'd1,
    ST_RESEND   = 2'd2
  } slot_state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             send;
    logic             release_en;
    logic [SlotW-1:0] slot;
    logic [31:0]      now;
    logic [15:0]      len;
    logic             seg;
    logic [31:0]      new_rto;
    logic [31:0]      new_limit;
    logic [31:0]      tmin;
    logic [31:0]      tmax;
  } ctl_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        stop;
    logic [31:0] earliest;
    logic [31:0] bytes;
    logic [5:0]  lost;
  } token_t;

  // per-cell status seen by the sequencer
  typedef struct packed {
    slot_state_e status;
    logic [31:0] rto;
    logic [15:0] len;
    logic        seg;
  } view_t;

  function automatic logic time_less(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d >= TimeWindow;
  endfunction

  function automatic logic [31:0] time_diff(logic [31:0] a, logic [31:0] b);
    return time_less(a, b) ? (b - a) : (a - b);
  endfunction

endpackage

// ===== design/rtt_cell.sv =====
module rtt_cell import rtt_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  token_t tok_i,
  output token_t tok_o,
  output view_t  view_o
);

  slot_state_e status_q, status_d;
  logic [31:0] rto_q, rto_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] limit_q, limit_d;
  logic [15:0] len_q, len_d;
  logic        seg_q, seg_d;
  token_t      tok_q, tok_d;

  logic        match;
  logic [31:0] early;
  logic [31:0] since;

  assign match = (ctl_i.slot == SlotW'(IDX));

  always_comb begin
    status_d = status_q;
    rto_d    = rto_q;
    sent_d   = sent_q;
    limit_d  = limit_q;
    len_d    = len_q;
    seg_d    = seg_q;
    tok_d    = tok_i;
    early    = tok_i.earliest;
    since    = '0;

    if (ctl_i.send && match && status_q != ST_INFLIGHT) begin
      if (rto_q == '0) begin
        rto_d   = ctl_i.new_rto;
        limit_d = ctl_i.new_limit;
      end
      sent_d   = ctl_i.now;
      len_d    = ctl_i.len;
      seg_d    = ctl_i.seg;
      status_d = ST_INFLIGHT;
    end else if (ctl_i.release_en && match) begin
      status_d = ST_EMPTY;
      rto_d    = '0;
    end

    // expiry check as the token passes
    if (tok_i.valid && !tok_i.stop && status_q == ST_INFLIGHT &&
        time_diff(ctl_i.now, sent_q) >= rto_q) begin
      if (tok_i.earliest == '0 || time_less(sent_q, tok_i.earliest)) begin
        early = sent_q;
      end
      since          = time_diff(ctl_i.now, early);
      tok_d.earliest = early;
      if (early != '0 &&
          (since >= ctl_i.tmax || (rto_q >= limit_q && since >= ctl_i.tmin))) begin
        tok_d.stop = 1'b1;
      end else begin
        if (seg_q) begin
          tok_d.bytes = tok_i.bytes - {16'd0, len_q};
        end
        tok_d.lost = tok_i.lost + 6'd1;
        rto_d      = {rto_q[30:0], 1'b0};
        status_d   = ST_RESEND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_EMPTY;
      rto_q    <= '0;
      tok_q    <= '0;
    end else begin
      status_q <= status_d;
      rto_q    <= rto_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sent_q  <= sent_d;
    limit_q <= limit_d;
    len_q   <= len_d;
    seg_q   <= seg_d;
  end

  assign tok_o  = tok_q;
  assign view_o = '{status: status_q, rto: rto_q, len: len_q, seg: seg_q};

endmodule

// ===== design/retransmit_timeout_table_unit.sv =====
// Retransmission timeout table.
// Requests enter on the s_axis channel: tuser carries the kind (send, tick,
// release, no-op), tdata the slot, time, fragment length and payload flag.
// One result per request leaves on m_axis: disconnect flag, lost count, bytes
// in transit, next deadline and the addressed slot's timeout.
// Config writes use the cfg channel (index 0..4), always ready, and must only
// be issued while the block is idle.
// Sequence: a send, release or no-op steps through the EXEC and FIN states before
// m_axis_tvalid is raised; a tick steps through SCAN and FIN, the scan token
// passing one cell per cycle along the row of slot cells.
// Throughput: one request at a time; each request is completed before the next
// is accepted.
// A new request is taken only once the previous result has been taken; if the
// receiver stalls, the result is held in the output register and s_axis_tready
// stays low.
// Reset empties every slot, zeroes the timeouts, the transit count, the
// earliest expiry and the deadline, and loads the default config values.
module retransmit_timeout_table_unit import rtt_pkg::*; #(
  parameter int unsigned SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // slot[4:0], time_ms[36:5],
                                      // frag_len[52:37], has_segment[53], zero
  input  logic [1:0]   s_axis_tuser,  // kind[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // disconnect[0], lost_count[6:1],
                                      // data_in_transit[38:7], next_deadline[70:39],
                                      // slot_timeout[102:71], zero
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } seq_e;

  seq_e        seq_q;
  logic [15:0] rtt_q, var_q;
  logic [7:0]  mult_q;
  logic [31:0] tmin_q, tmax_q;

  kind_e       kind_q;
  logic [4:0]  slot_q;
  logic [31:0] now_q;
  logic [15:0] len_q;
  logic        seg_q;

  logic [31:0] earliest_q, bytes_q, deadline_q;
  logic        disc_q;
  logic [5:0]  lost_q;
  token_t      launch_q;

  logic          out_valid_q;
  logic [103:0]  out_data_q;

  token_t        tok [SLOTS+1];
  view_t         views [SLOTS];
  ctl_t          ctl;
  logic          slot_ok;
  logic [IdxW-1:0] slot_idx;
  view_t         sel;
  logic          any_inflight;
  logic [31:0]   new_rto, new_limit, slot_rto_now;
  logic          send_ok, rel_sub;
  logic          accept;

  assign slot_ok  = (32'(slot_q) < SLOTS);
  assign slot_idx = IdxW'(slot_q);
  assign sel      = slot_ok ? views[slot_idx] : '0;

  always_comb begin
    any_inflight = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      any_inflight = any_inflight | (views[i].status == ST_INFLIGHT);
    end
  end

  assign new_rto   = 32'(rtt_q) + {14'd0, var_q, 2'b00};
  assign new_limit = 32'({24'd0, mult_q} * new_rto);

  assign send_ok = (seq_q == S_EXEC) && kind_q == KIND_SEND && slot_ok &&
                   sel.status != ST_INFLIGHT;
  assign rel_sub = (seq_q == S_EXEC) && kind_q == KIND_RELEASE && slot_ok &&
                   sel.status == ST_INFLIGHT && sel.seg;
  assign slot_rto_now = (sel.rto == '0) ? new_rto : sel.rto;

  assign ctl = '{
    send:       send_ok,
    release_en: (seq_q == S_EXEC) && kind_q == KIND_RELEASE && slot_ok,
    slot:       SlotW'(slot_q),
    now:        now_q,
    len:        len_q,
    seg:        seg_q,
    new_rto:    new_rto,
    new_limit:  new_limit,
    tmin:       tmin_q,
    tmax:       tmax_q
  };

  // the row of slot cells; the scan token enters at cell 0
  assign tok[0] = launch_q;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rtt_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .view_o (views[g])
    );
  end

  assign s_axis_tready = (seq_q == S_IDLE) && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      rtt_q       <= 16'd500;
      var_q       <= 16'd0;
      mult_q      <= 8'd32;
      tmin_q      <= 32'd5000;
      tmax_q      <= 32'd30000;
      earliest_q  <= '0;
      bytes_q     <= '0;
      deadline_q  <= '0;
      disc_q      <= 1'b0;
      lost_q      <= '0;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NOP;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegRtt:  rtt_q  <= cfg_data_i[15:0];
          RegVar:  var_q  <= cfg_data_i[15:0];
          RegMult: mult_q <= cfg_data_i[7:0];
          RegTmin: tmin_q <= cfg_data_i;
          RegTmax: tmax_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (seq_q)
        S_IDLE: begin
          if (accept) begin
            kind_q <= kind_e'(s_axis_tuser);
            disc_q <= 1'b0;
            lost_q <= '0;
            if (kind_e'(s_axis_tuser) == KIND_TICK) begin
              launch_q <= '{valid: 1'b1, stop: 1'b0, earliest: earliest_q,
                            bytes: bytes_q, lost: 6'd0};
              seq_q    <= S_SCAN;
            end else begin
              seq_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (send_ok) begin
            if (!any_inflight) begin
              deadline_q <= now_q + slot_rto_now;
            end
            if (seg_q) begin
              bytes_q <= bytes_q + {16'd0, len_q};
            end
          end else if (rel_sub) begin
            bytes_q <= bytes_q - {16'd0, sel.len};
          end
          seq_q <= S_FIN;
        end
        S_SCAN: begin
          // token is launched for one cycle only
          launch_q <= '0;
          if (tok[SLOTS].valid) begin
            earliest_q <= tok[SLOTS].earliest;
            bytes_q    <= tok[SLOTS].bytes;
            lost_q     <= tok[SLOTS].lost;
            disc_q     <= tok[SLOTS].stop;
            seq_q      <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_q <= 1'b1;
          seq_q       <= S_IDLE;
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  // request payload and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= s_axis_tdata[4:0];
      now_q  <= s_axis_tdata[36:5];
      len_q  <= s_axis_tdata[52:37];
      seg_q  <= s_axis_tdata[53];
    end
    if (seq_q == S_FIN) begin
      out_data_q <= {1'b0, sel.rto, deadline_q, bytes_q, lost_q, disc_q};
    end
  end

endmodule
